// File: rtl/core/qss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qss_pkg
// Shared types and constants of the quad scanline span block.
// ----------------------------------------------------------------------------
package qss_pkg;
	localparam int FRAC_BITS  = 8;
	localparam int CW         = 24;  // corner coordinate width
	localparam int RW         = 12;  // row / column width
	localparam int QBITS      = 12;  // quotient bits produced by the divider
	localparam int NUM_W      = 52;  // crossing numerator
	localparam int DD_W       = 25 + FRAC_BITS;  // divisor |dy| << FRAC_BITS
	localparam int REM_W      = DD_W + QBITS + 1;
	localparam int EDGE_STG   = 4;
	localparam int NSTAGE     = EDGE_STG + QBITS + 1;

	typedef enum logic [2:0] {
		REG_C0X = 3'd0, REG_C0Y = 3'd1, REG_C1X = 3'd2, REG_C1Y = 3'd3,
		REG_C2X = 3'd4, REG_C2Y = 3'd5, REG_C3X = 3'd6, REG_C3Y = 3'd7
	} cfg_idx_t;

	// edge front end to divider lane
	typedef struct packed {
		logic             hit;
		logic             neg;
		logic             sat;
		logic [REM_W-1:0] rem;
		logic [DD_W-1:0]  dd;
	} div_in_t;

	// divider lane result
	typedef struct packed {
		logic             hit;
		logic             neg;
		logic             sat;
		logic             nz;
		logic [QBITS-1:0] q;
	} edge_res_t;
endpackage
`default_nettype wire

// File: rtl/core/qss_row_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qss_row_if
// Row request channel.
// ----------------------------------------------------------------------------
interface qss_row_if;
	logic        valid;
	logic        ready;
	logic [11:0] row;
	modport source (output valid, output row, input ready);
	modport sink (input valid, input row, output ready);
endinterface
`default_nettype wire

// File: rtl/core/qss_span_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qss_span_if
// Span result channel.
// ----------------------------------------------------------------------------
interface qss_span_if;
	logic        valid;
	logic        ready;
	logic        span_valid;
	logic [11:0] span_left;
	logic [11:0] span_right;
	modport source (output valid, output span_valid, output span_left,
		output span_right, input ready);
	modport sink (input valid, input span_valid, input span_left,
		input span_right, output ready);
endinterface
`default_nettype wire

// File: rtl/core/qss_edge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qss_edge
// Front end of one edge: row test, crossing numerator and divisor.
// ----------------------------------------------------------------------------
module qss_edge
	import qss_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic [EDGE_STG-1:0]  en,
	input  wire logic signed [CW-1:0] x1,
	input  wire logic signed [CW-1:0] y1,
	input  wire logic signed [CW-1:0] x2,
	input  wire logic signed [CW-1:0] y2,
	input  wire logic [RW-1:0]        row,
	output div_in_t                   dout
);
	logic signed [25:0] rf;
	logic               hit_c;

	logic               hit_s1;
	logic signed [23:0] x1_s1;
	logic signed [24:0] dy_s1;
	logic signed [24:0] dx_s1;
	logic signed [25:0] ry_s1;

	logic               hit_s2;
	logic               dyneg_s2;
	logic [24:0]        dyabs_s2;
	logic signed [48:0] p1_s2;
	logic signed [50:0] p2_s2;

	logic               hit_s3;
	logic signed [NUM_W-1:0] num_s3;
	logic [DD_W-1:0]    dd_s3;
	logic signed [NUM_W-1:0] sum;

	assign rf = $signed({6'b0, row, {FRAC_BITS{1'b0}}});
	assign hit_c = (y1 != y2) &&
		((y1 <= rf && rf <= y2) || (y1 >= rf && rf >= y2));
	assign sum = p1_s2 + p2_s2;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			hit_s1 <= hit_c;
			x1_s1  <= x1;
			dy_s1  <= y2 - y1;
			dx_s1  <= x2 - x1;
			ry_s1  <= rf - y1;
		end
		if (en[1]) begin
			hit_s2   <= hit_s1;
			dyneg_s2 <= dy_s1[24];
			dyabs_s2 <= dy_s1[24] ? 25'(-dy_s1) : 25'(dy_s1);
			p1_s2    <= x1_s1 * dy_s1;
			p2_s2    <= ry_s1 * dx_s1;
		end
		if (en[2]) begin
			hit_s3 <= hit_s2;
			num_s3 <= dyneg_s2 ? -sum : sum;
			dd_s3  <= {dyabs_s2, {FRAC_BITS{1'b0}}};
		end
		if (en[3]) begin
			dout.hit <= hit_s3;
			dout.neg <= num_s3[NUM_W-1];
			// quotient of 2^QBITS or more clamps anyway
			dout.sat <= !num_s3[NUM_W-1] &&
				(num_s3[NUM_W-2:0] >= {{(NUM_W-1-DD_W-QBITS){1'b0}}, dd_s3, {QBITS{1'b0}}});
			dout.rem <= num_s3[REM_W-1:0];
			dout.dd  <= dd_s3;
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/qss_div_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qss_div_lane
// Restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module qss_div_lane
	import qss_pkg::*;
(
	input  wire logic              clk,
	input  wire logic [QBITS-1:0]  en,
	input  wire div_in_t           din,
	output edge_res_t              dout
);
	logic [REM_W-1:0] rem_s [QBITS+1];
	logic [DD_W-1:0]  dd_s  [QBITS+1];
	logic [QBITS-1:0] q_s   [QBITS+1];
	logic             hit_s [QBITS+1];
	logic             neg_s [QBITS+1];
	logic             sat_s [QBITS+1];

	assign rem_s[0] = din.rem;
	assign dd_s[0]  = din.dd;
	assign q_s[0]   = '0;
	assign hit_s[0] = din.hit;
	assign neg_s[0] = din.neg;
	assign sat_s[0] = din.sat;

	for (genvar k = 0; k < QBITS; k++) begin : g_step
		localparam int SH = QBITS - 1 - k;
		logic [REM_W-1:0] trial;
		logic             ge;
		assign trial = {{(REM_W-DD_W){1'b0}}, dd_s[k]} << SH;
		assign ge    = rem_s[k] >= trial;
		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k+1] <= ge ? rem_s[k] - trial : rem_s[k];
				q_s[k+1]   <= {q_s[k][QBITS-2:0], ge};
				dd_s[k+1]  <= dd_s[k];
				hit_s[k+1] <= hit_s[k];
				neg_s[k+1] <= neg_s[k];
				sat_s[k+1] <= sat_s[k];
			end
		end
	end

	assign dout.hit = hit_s[QBITS];
	assign dout.neg = neg_s[QBITS];
	assign dout.sat = sat_s[QBITS];
	assign dout.nz  = rem_s[QBITS] != '0;
	assign dout.q   = q_s[QBITS];
endmodule
`default_nettype wire

// File: rtl/core/quad_scanline_span.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quad_scanline_span
// Horizontal span of one screen row across a quad held in registers.
// ----------------------------------------------------------------------------
// One row is taken per cycle while the pipeline is not stalled; the
// pipeline has four front-end stages per edge (row test, two multiplies,
// sum, range check), a 12-stage divider with one quotient bit per stage for
// each edge of the quad, and a merge and output register at the end. Each
// stage holds its item when the one after it is full and held, so stalls
// lose nothing and empty stages fill up while the output waits.
module quad_scanline_span
	import qss_pkg::*;
#(
	parameter int SCREEN_WIDTH  = 1024,
	parameter int SCREEN_HEIGHT = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_idx,
	input  wire logic [23:0] cfg_data,
	qss_row_if.sink          rows,
	qss_span_if.source       spans
);
	localparam logic [12:0] WMAX = 13'(SCREEN_WIDTH - 1);
	localparam logic signed [16:0] HMAX = 17'(SCREEN_HEIGHT - 1);

	logic signed [CW-1:0] cx_q [4];
	logic signed [CW-1:0] cy_q [4];
	logic [NSTAGE-1:0]    v_q;
	logic [NSTAGE-1:0]    rdy;
	logic                 inb_s [NSTAGE-1];
	logic signed [15:0]   ty [4];
	logic signed [15:0]   ymin, ymax;
	logic signed [16:0]   rs;
	logic                 inb;
	div_in_t              din [4];
	edge_res_t            res [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 4; c++) begin
				cx_q[c] <= '0;
				cy_q[c] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				REG_C0X: cx_q[0] <= cfg_data;
				REG_C0Y: cy_q[0] <= cfg_data;
				REG_C1X: cx_q[1] <= cfg_data;
				REG_C1Y: cy_q[1] <= cfg_data;
				REG_C2X: cx_q[2] <= cfg_data;
				REG_C2Y: cy_q[2] <= cfg_data;
				REG_C3X: cx_q[3] <= cfg_data;
				REG_C3Y: cy_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// bounding rows, corner y truncated toward zero
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			ty[c] = cy_q[c][CW-1:FRAC_BITS] +
				16'((cy_q[c][CW-1] && cy_q[c][FRAC_BITS-1:0] != '0) ? 1 : 0);
		end
		ymin = ty[0];
		ymax = ty[0];
		for (int c = 1; c < 4; c++) begin
			if (ty[c] < ymin) ymin = ty[c];
			if (ty[c] > ymax) ymax = ty[c];
		end
		rs  = $signed({5'b0, rows.row});
		inb = (rs >= 17'(ymin)) && (rs <= 17'(ymax)) && (rs <= HMAX);
	end

	// stage handshake, each stage holds while the next one is full and held
	always_comb begin
		rdy[NSTAGE-1] = !v_q[NSTAGE-1] || spans.ready;
		for (int k = NSTAGE - 2; k >= 0; k--) rdy[k] = !v_q[k] || rdy[k+1];
	end
	assign rows.ready = rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (rdy[0]) v_q[0] <= rows.valid;
			for (int k = 1; k < NSTAGE; k++) begin
				if (rdy[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) inb_s[0] <= inb;
		for (int k = 1; k < NSTAGE - 1; k++) begin
			if (rdy[k]) inb_s[k] <= inb_s[k-1];
		end
	end

	// edges 3->0, 0->1, 1->2, 2->3
	for (genvar e = 0; e < 4; e++) begin : g_edge
		qss_edge u_edge (
			.clk (clk),
			.en  (rdy[EDGE_STG-1:0]),
			.x1  (cx_q[(e + 3) % 4]),
			.y1  (cy_q[(e + 3) % 4]),
			.x2  (cx_q[e]),
			.y2  (cy_q[e]),
			.row (rows.row),
			.dout(din[e])
		);
		qss_div_lane u_div (
			.clk (clk),
			.en  (rdy[EDGE_STG+QBITS-1:EDGE_STG]),
			.din (din[e]),
			.dout(res[e])
		);
	end

	// merge of the four crossings
	logic [12:0] up_c [4];
	logic [12:0] tr_c [4];
	logic [12:0] lft, rgt;
	logic [2:0]  cnt;
	logic        ok;

	always_comb begin
		for (int e = 0; e < 4; e++) begin
			if (res[e].neg) begin
				up_c[e] = '0;
				tr_c[e] = '0;
			end else if (res[e].sat) begin
				up_c[e] = WMAX;
				tr_c[e] = WMAX;
			end else begin
				up_c[e] = {1'b0, res[e].q} + 13'(res[e].nz);
				tr_c[e] = {1'b0, res[e].q};
				if (up_c[e] > WMAX) up_c[e] = WMAX;
				if (tr_c[e] > WMAX) tr_c[e] = WMAX;
			end
		end
		lft = WMAX;
		rgt = '0;
		cnt = '0;
		for (int e = 0; e < 4; e++) begin
			if (res[e].hit) begin
				cnt = cnt + 3'd1;
				if (up_c[e] < lft) lft = up_c[e];
				if (tr_c[e] > rgt) rgt = tr_c[e];
			end
		end
		ok = inb_s[NSTAGE-2] && (cnt >= 3'd2) && (lft <= rgt);
	end

	always_ff @(posedge clk) begin
		if (rdy[NSTAGE-1]) begin
			spans.span_valid <= ok;
			spans.span_left  <= ok ? lft[11:0] : '0;
			spans.span_right <= ok ? rgt[11:0] : '0;
		end
	end
	assign spans.valid = v_q[NSTAGE-1];
endmodule
`default_nettype wire

// File: rtl/core/qss_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qss_checker
// Port-level checks of the span block, bound to the top level.
// ----------------------------------------------------------------------------
module qss_checker #(
	parameter int SCREEN_WIDTH = 1024
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        span_valid,
	input wire logic [11:0] span_left,
	input wire logic [11:0] span_right
);
	// a stalled transfer keeps its result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(span_left) &&
		$stable(span_right) && $stable(span_valid))
		else $error("span result changed while stalled");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !span_valid |-> span_left == '0 && span_right == '0)
		else $error("invalid span carries columns");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && span_valid |-> span_left <= span_right)
		else $error("span left beyond right");

	a_screen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && span_valid |-> 32'(span_right) < SCREEN_WIDTH)
		else $error("span off screen");
endmodule

bind quad_scanline_span qss_checker #(.SCREEN_WIDTH(SCREEN_WIDTH)) u_qss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (spans.valid),
	.out_ready (spans.ready),
	.span_valid(spans.span_valid),
	.span_left (spans.span_left),
	.span_right(spans.span_right)
);
`default_nettype wire
